// ===== design/rocacc_pkg.sv =====
// shared types, constants and codes for the roc area accumulator
package rocacc_pkg;

    localparam int COUNT_BITS_DEF   = 24;
    localparam int SCORE_BITS_DEF   = 32;
    localparam int SCORE_W          = 32;
    localparam int AUC_W            = 23;
    localparam int OUT_CNT_W        = 24;
    localparam int LIMIT_W          = 16;
    localparam int Q_BITS           = 24;
    localparam int HALF_SCALE_SHIFT = 17;

    localparam logic [AUC_W-1:0]   AUC_FULL      = 23'd6553600;
    localparam logic [LIMIT_W-1:0] NEG_LIMIT_RST = 16'd50;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_ROC50_MODE = 1'b0;
    localparam t_reg_idx REG_NEG_LIMIT  = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      is_positive;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic [AUC_W-1:0]     auc_percent;
        logic                 degenerate;
        logic [OUT_CNT_W-1:0] positives;
        logic [OUT_CNT_W-1:0] negatives;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACC,
        ST_FMUL,
        ST_FACC,
        ST_DEN,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic eval;
        logic mul_area;
        logic mul_den;
        logic acc;
        logic start;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic last;
        logic skip_div;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== design/roc_auc_accumulator_core.sv =====
// roc area accumulator top level: counts, bin area, final percentage
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_wr_en                 | i_cfg_index, i_cfg_data
//
// a non-last item steps through accept, multiply of the closed bin, area add
// a last item adds the final bin, the denominator multiply and a 24 step divide;
// the divide is skipped when either count or the denominator is zero
// a result waiting in the output register holds the sequencer in its done state,
// and input stays not ready until the register frees
// synchronous active-low reset clears counts and area and restores register defaults
module roc_auc_accumulator_core import rocacc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_wr_en,
    input  t_reg_idx           i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int CB     = COUNT_BITS;
    localparam int AREA_W = 2 * CB + 1;
    localparam int LIM_W  = (CB > LIMIT_W) ? CB : LIMIT_W;
    localparam int MB     = ((CB + 1) > LIM_W) ? (CB + 1) : LIM_W;
    localparam int PROD_W = CB + MB;
    localparam int DEN_W  = CB + LIM_W;
    localparam int DIV_W  = DEN_W + Q_BITS - 1;
    localparam int A25_W  = AREA_W + 5;

    t_ctrl w_ctrl;
    t_stat w_stat;

    t_in_item           r_item;
    logic               r_roc50;
    logic [LIMIT_W-1:0] r_limit;
    logic [CB-1:0]      r_pos;
    logic [CB-1:0]      r_neg;
    logic [CB-1:0]      r_pos_brk;
    logic [CB-1:0]      r_neg_brk;
    logic [SCORE_BITS-1:0] r_prev;
    logic               r_have_prev;
    logic [AREA_W-1:0]  r_area;
    logic [PROD_W-1:0]  r_prod;
    logic               r_do_add;
    logic [AUC_W-1:0]   r_auc;
    logic               r_out_valid;
    t_out_item          r_out;

    logic                  w_in_fire;
    logic                  w_out_free;
    logic [SCORE_BITS-1:0] w_score;
    logic                  w_open;
    logic                  w_new;
    logic [CB-1:0]         w_dx;
    logic [CB:0]           w_sy;
    logic [CB-1:0]         w_mul_a;
    logic [MB-1:0]         w_mul_b;
    logic [PROD_W-1:0]     w_prod;
    logic [AREA_W:0]       w_sum;
    logic [AREA_W-1:0]     w_area_next;
    logic                  w_degen;
    logic [CB-1:0]         w_pos_inc;
    logic [CB-1:0]         w_neg_inc;
    logic [A25_W-1:0]      w_area_ext;
    logic [A25_W-1:0]      w_area25;
    logic [DIV_W-1:0]      w_num;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [AUC_W-1:0]      w_quot;

    assign w_in_fire  = i_in_valid && w_ctrl.in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_score = SCORE_BITS'($unsigned(r_item.score));
    assign w_open  = !r_roc50 || (LIM_W'(r_neg) < LIM_W'(r_limit));
    assign w_new   = !r_have_prev || (w_score != r_prev);
    assign w_dx    = (r_neg >= r_neg_brk) ? (r_neg - r_neg_brk) : '0;
    assign w_sy    = {1'b0, r_pos} + {1'b0, r_pos_brk};

    // one multiplier serves bin areas and the final denominator
    assign w_mul_a = w_ctrl.mul_den ? r_pos : w_dx;
    assign w_mul_b = w_ctrl.mul_den ? (r_roc50 ? MB'(r_limit) : MB'(r_neg)) : MB'(w_sy);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    assign w_sum       = {1'b0, r_area} + {1'b0, AREA_W'(r_prod)};
    assign w_area_next = w_sum[AREA_W] ? '1 : w_sum[AREA_W-1:0];

    assign w_degen   = (r_pos == '0) || (r_neg == '0);
    assign w_pos_inc = (r_pos == '1) ? r_pos : r_pos + CB'(1);
    assign w_neg_inc = (r_neg == '1) ? r_neg : r_neg + CB'(1);

    // area times 3276800 = area times 25, shifted left 17
    assign w_area_ext = A25_W'(r_area);
    assign w_area25   = (w_area_ext << 4) + (w_area_ext << 3) + w_area_ext;
    assign w_num      = DIV_W'(w_area25) << HALF_SCALE_SHIFT;

    assign w_stat.last     = r_item.last;
    assign w_stat.skip_div = w_degen || (r_prod == '0);
    assign w_stat.div_done = w_div_done;
    assign w_stat.out_free = w_out_free;

    rocacc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_in_fire),
        .i_stat    (w_stat),
        .o_ctrl    (w_ctrl)
    );

    rocacc_div #(
        .DEN_W (DEN_W),
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctrl.start),
        .i_num   (w_num),
        .i_den   (DEN_W'(r_prod)),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roc50     <= 1'b0;
            r_limit     <= NEG_LIMIT_RST;
            r_pos       <= '0;
            r_neg       <= '0;
            r_pos_brk   <= '0;
            r_neg_brk   <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_area      <= '0;
            r_do_add    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_ROC50_MODE: r_roc50 <= i_cfg_data[0];
                    REG_NEG_LIMIT:  r_limit <= i_cfg_data;
                    default:        r_roc50 <= r_roc50;
                endcase
            end
            if (w_ctrl.eval) begin
                r_do_add <= w_new && w_open;
                if (w_new && w_open) begin
                    r_neg_brk   <= r_neg;
                    r_pos_brk   <= r_pos;
                    r_prev      <= w_score;
                    r_have_prev <= 1'b1;
                end
                if (r_item.is_positive) begin
                    r_pos <= w_pos_inc;
                end else if (w_open) begin
                    r_neg <= w_neg_inc;
                end
            end else if (w_ctrl.mul_area) begin
                r_do_add <= 1'b1;
            end
            if (w_ctrl.acc && r_do_add) r_area <= w_area_next;
            if (w_ctrl.finish) begin
                r_pos       <= '0;
                r_neg       <= '0;
                r_pos_brk   <= '0;
                r_neg_brk   <= '0;
                r_prev      <= '0;
                r_have_prev <= 1'b0;
                r_area      <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) r_item <= i_in_data;
        if (w_ctrl.mul_area || w_ctrl.mul_den) r_prod <= w_prod;
        if (w_ctrl.mul_den) begin
            r_auc <= '0;
        end else if (w_div_done) begin
            r_auc <= w_quot;
        end
        if (w_ctrl.finish) begin
            r_out.auc_percent <= r_auc;
            r_out.degenerate  <= w_degen;
            r_out.positives   <= OUT_CNT_W'(r_pos);
            r_out.negatives   <= OUT_CNT_W'(r_neg);
        end
    end

    assign o_in_ready  = w_ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_busy)
        else $error("divider busy while accepting beats");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.finish |=> o_out_valid && (r_area == '0) && (r_pos == '0) && !r_have_prev)
        else $error("set state not cleared after result");

    a_auc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.auc_percent <= AUC_FULL))
        else $error("auc above full scale");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |-> (o_out_data.auc_percent == '0))
        else $error("degenerate set with nonzero auc");

endmodule

// ===== design/rocacc_ctrl.sv =====
// sequencer that steps the shared multiplier, accumulator and divider
module rocacc_ctrl import rocacc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) n_state = ST_EVAL;
            end
            ST_EVAL:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = i_stat.last ? ST_FMUL : ST_IDLE;
            end
            ST_FMUL:  n_state = ST_FACC;
            ST_FACC:  n_state = ST_DEN;
            ST_DEN:   n_state = ST_START;
            ST_START: begin
                n_state = i_stat.skip_div ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.in_ready = (r_state == ST_IDLE);
        o_ctrl.eval     = (r_state == ST_EVAL);
        o_ctrl.mul_area = (r_state == ST_EVAL) || (r_state == ST_FMUL);
        o_ctrl.mul_den  = (r_state == ST_DEN);
        o_ctrl.acc      = (r_state == ST_ACC) || (r_state == ST_FACC);
        o_ctrl.start    = (r_state == ST_START) && !i_stat.skip_div;
        o_ctrl.finish   = (r_state == ST_DONE) && i_stat.out_free;
    end

endmodule

// ===== design/rocacc_div.sv =====
// restoring divider, one quotient bit per cycle, result capped at full scale
module rocacc_div import rocacc_pkg::*; #(
    parameter int DEN_W = 2 * COUNT_BITS_DEF,
    parameter int DIV_W = 2 * COUNT_BITS_DEF + Q_BITS - 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [AUC_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvs;
    logic [Q_BITS-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              w_ge;

    assign w_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dvs <= DIV_W'(i_den) << (Q_BITS - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) r_rem <= r_rem - r_dvs;
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[Q_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = (r_q > Q_BITS'(AUC_FULL)) ? AUC_FULL : r_q[AUC_W-1:0];

endmodule
